/* rtl/lcm_pkg.sv */
// ----------------------------------------------------------------------------
// lcm_pkg
// shared types for the lcm controller and datapath
// ----------------------------------------------------------------------------
package lcm_pkg;

    localparam int RES_W = 64;

    // controller to datapath
    typedef struct packed {
        logic load;       // capture operands
        logic zero_res;   // result forced to zero
        logic gcd_load;   // divider gets p / q
        logic quot_load;  // divider gets first operand / gcd
        logic div_step;   // one restoring division step
        logic swap;       // p <= q, q <= remainder
        logic mul;        // quotient times second operand
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic any_zero;
        logic q_zero;
    } status_t;

endpackage

/* rtl/lcm_dp.sv */
// ----------------------------------------------------------------------------
// lcm_dp
// operand registers, shared bit-serial divider and result multiplier
// ----------------------------------------------------------------------------
module lcm_dp #(
    parameter int W = 32
) (
    input  logic                clk,
    input  logic [31:0]         first_value,
    input  logic [31:0]         second_value,
    input  lcm_pkg::cmd_t       cmd,
    output lcm_pkg::status_t    status,
    output logic [63:0]         multiple
);
    import lcm_pkg::*;

    logic [W-1:0]     a0_reg, b0_reg;
    logic [W-1:0]     p_reg, q_reg;
    logic [W-1:0]     dvd_reg, dvd_next;
    logic [W-1:0]     dvs_reg, dvs_next;
    logic [W-1:0]     rr_reg, rr_next;
    logic [RES_W-1:0] res_reg, res_next;
    logic [W:0]       trial;
    logic [W:0]       diff;
    logic [2*W-1:0]   prod;

    // restoring division step
    assign trial = {rr_reg, dvd_reg[W-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign prod  = dvd_reg * b0_reg;

    always_comb
    begin
        dvd_next = dvd_reg;
        dvs_next = dvs_reg;
        rr_next  = rr_reg;
        res_next = res_reg;
        if (cmd.gcd_load)
        begin
            dvd_next = p_reg;
            dvs_next = q_reg;
            rr_next  = '0;
        end
        else if (cmd.quot_load)
        begin
            dvd_next = a0_reg;
            dvs_next = p_reg;
            rr_next  = '0;
        end
        else if (cmd.div_step)
        begin
            if (!diff[W])
            begin
                rr_next  = diff[W-1:0];
                dvd_next = {dvd_reg[W-2:0], 1'b1};
            end
            else
            begin
                rr_next  = trial[W-1:0];
                dvd_next = {dvd_reg[W-2:0], 1'b0};
            end
        end
        if (cmd.zero_res)
            res_next = '0;
        else if (cmd.mul)
            res_next = RES_W'(prod);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            a0_reg <= first_value[W-1:0];
            b0_reg <= second_value[W-1:0];
            p_reg  <= first_value[W-1:0];
            q_reg  <= second_value[W-1:0];
        end
        else if (cmd.swap)
        begin
            p_reg <= q_reg;
            q_reg <= rr_reg;
        end
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
        rr_reg  <= rr_next;
        res_reg <= res_next;
    end

    assign status.any_zero = (a0_reg == '0) || (b0_reg == '0);
    assign status.q_zero   = (q_reg == '0);
    assign multiple        = res_reg;

endmodule

/* rtl/lcm_ctrl.sv */
// ----------------------------------------------------------------------------
// lcm_ctrl
// sequencer for the euclid loop, quotient division and multiply
// ----------------------------------------------------------------------------
module lcm_ctrl #(
    parameter int W = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  lcm_pkg::status_t    status,
    output lcm_pkg::cmd_t       cmd,
    output logic                busy,
    output logic                done
);
    import lcm_pkg::*;

    localparam int CW = $clog2(W);

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_CHK       = 4'd1;
    localparam logic [3:0] S_GCD_LOAD  = 4'd2;
    localparam logic [3:0] S_GCD_DIV   = 4'd3;
    localparam logic [3:0] S_GCD_SWAP  = 4'd4;
    localparam logic [3:0] S_QUOT_LOAD = 4'd5;
    localparam logic [3:0] S_QUOT_DIV  = 4'd6;
    localparam logic [3:0] S_MUL       = 4'd7;
    localparam logic [3:0] S_OUT       = 4'd8;

    logic [3:0]    state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          last;

    assign last = (cnt_reg == CW'(W - 1));

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CHK;
                end
            end
            S_CHK:
            begin
                if (status.any_zero)
                begin
                    cmd.zero_res = 1'b1;
                    state_next   = S_OUT;
                end
                else
                    state_next = S_GCD_LOAD;
            end
            S_GCD_LOAD:
            begin
                cnt_next = '0;
                if (status.q_zero)
                    state_next = S_QUOT_LOAD;
                else
                begin
                    cmd.gcd_load = 1'b1;
                    state_next   = S_GCD_DIV;
                end
            end
            S_GCD_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (last)
                    state_next = S_GCD_SWAP;
            end
            S_GCD_SWAP:
            begin
                cmd.swap   = 1'b1;
                state_next = S_GCD_LOAD;
            end
            S_QUOT_LOAD:
            begin
                cmd.quot_load = 1'b1;
                cnt_next      = '0;
                state_next    = S_QUOT_DIV;
            end
            S_QUOT_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (last)
                    state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
                state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_OUT);

    // accepted command always goes to the operand check
    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (state_reg == S_CHK))
        else $error("accepted command did not reach operand check");

    // gcd division ends after exactly the last step
    a_gcd_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_GCD_DIV && last) |=> (state_reg == S_GCD_SWAP))
        else $error("gcd division did not end on last step");

    // result strobe lasts one cycle and frees the block
    a_done: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> (!done && !busy))
        else $error("result strobe longer than one cycle");

    // operands with a zero never reach the divider
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CHK && status.any_zero) |=> (state_reg == S_OUT))
        else $error("zero operand not short-cut");

endmodule

/* rtl/lcm_via_euclid_gcd_top.sv */
// ----------------------------------------------------------------------------
// lcm_via_euclid_gcd_top
// least common multiple of two unsigned operands via euclid's gcd
// ----------------------------------------------------------------------------
// usage
//   command channel: drive first_value and second_value and raise start;
//   the transfer happens at the rising edge where start is high and busy
//   is low. only the low OPERAND_WIDTH bits of each operand are used.
//   result channel: multiple is valid for exactly one cycle, marked by
//   done; the receiver cannot stall, so it must take it in that cycle.
// timing
//   all work goes through one bit-serial restoring divider, one quotient
//   bit per cycle; each euclid step is a load, W division steps and a
//   swap, with W = OPERAND_WIDTH. after the euclid remainder steps come
//   the quotient load, W division steps, the multiply and the done cycle;
//   a zero operand short-cuts past the divider to the done cycle.
//   busy stays high until the done cycle has passed, so the next command
//   can transfer in the cycle after done; one command is in flight.
// reset
//   rst_n clears the sequencer to idle and drops any command in flight;
//   no stray done strobe follows.
// ----------------------------------------------------------------------------
module lcm_via_euclid_gcd_top #(
    parameter int OPERAND_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] first_value,
    input  logic [31:0] second_value,
    output logic        done,
    output logic [63:0] multiple
);
    import lcm_pkg::*;

    // command and status between sequencer and datapath
    cmd_t    cmd;
    status_t status;

    // sequencer: euclid loop, quotient division, multiply, strobe
    lcm_ctrl #(
        .W (OPERAND_WIDTH)
    ) u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    // datapath: operand registers, shared divider, result register
    lcm_dp #(
        .W (OPERAND_WIDTH)
    ) u_dp (
        .clk          (clk),
        .first_value  (first_value),
        .second_value (second_value),
        .cmd          (cmd),
        .status       (status),
        .multiple     (multiple)
    );

endmodule
